>>> hdl/sgpr_pkg.sv
`timescale 1ns / 1ps
package sgpr_pkg;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type REG_VOLUME     = 3'd0;
   localparam csr_index_type REG_BALANCE    = 3'd1;
   localparam csr_index_type REG_INPUT_RATE = 3'd2;
   localparam csr_index_type REG_MONO_INPUT = 3'd3;

   localparam logic [7:0]         VOL_MAX    = 8'd254;
   localparam logic signed [5:0]  BAL_MAX    = 6'sd16;
   localparam logic signed [5:0]  BAL_MIN    = -6'sd16;
   localparam logic [4:0]         BAL_ONE    = 5'd16;
   localparam logic [15:0]        OUT_RATE   = 16'd48000;
   localparam logic [15:0]        MIN_RATE   = 16'd8000;
   localparam logic [15:0]        FRAC_MUL   = 16'd44739;
   localparam logic [15:0]        FRAC_BIAS  = 16'd32768;
   localparam logic [15:0]        Q15_HALF   = 16'd16384;
   localparam logic [15:0]        GAIN_MAX   = 16'd32768;
   localparam logic [22:0]        GAIN_RECIP = 23'd4227330;
   localparam logic [6:0]         GAIN_DIV   = 7'd127;
   localparam logic [5:0]         GAIN_BIAS  = 6'd63;

   typedef struct packed {
      logic [7:0]        volume;
      logic signed [5:0] balance;
      logic [15:0]       input_rate;
      logic              mono_input;
   } cfg_type;

   typedef struct packed {
      logic load_item;
      logic calc_gain;
      logic corr_gain;
      logic scale;
      logic round_out;
      logic peak;
      logic frac;
      logic mul;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic pass_mode;
      logic phase_last;
      logic out_free;
   } status_type;

endpackage

>>> hdl/sgpr_csr.sv
`timescale 1ns / 1ps
module sgpr_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  sgpr_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata,
   output sgpr_pkg::cfg_type      cfg,
   output logic                   rate_clear
);

   logic [7:0]        volume_ff, volume_in;
   logic signed [5:0] balance_ff, balance_in;
   logic [15:0]       rate_ff, rate_in;
   logic              mono_ff, mono_in;
   logic              write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;

   always_comb begin
      volume_in  = volume_ff;
      balance_in = balance_ff;
      rate_in    = rate_ff;
      mono_in    = mono_ff;
      rate_clear = 1'b0;
      if (write) begin
         unique case (csr_index)
            sgpr_pkg::REG_VOLUME: begin
               volume_in = csr_wdata[7:0];
            end
            sgpr_pkg::REG_BALANCE: begin
               balance_in = csr_wdata[5:0];
            end
            sgpr_pkg::REG_INPUT_RATE: begin
               if (csr_wdata >= sgpr_pkg::MIN_RATE && csr_wdata <= sgpr_pkg::OUT_RATE &&
                   csr_wdata != rate_ff) begin
                  rate_in    = csr_wdata;
                  rate_clear = 1'b1;
               end
            end
            sgpr_pkg::REG_MONO_INPUT: begin
               mono_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff  <= sgpr_pkg::VOL_MAX;
         balance_ff <= '0;
         rate_ff    <= sgpr_pkg::OUT_RATE;
         mono_ff    <= 1'b0;
      end else begin
         volume_ff  <= volume_in;
         balance_ff <= balance_in;
         rate_ff    <= rate_in;
         mono_ff    <= mono_in;
      end
   end

   assign cfg.volume     = volume_ff;
   assign cfg.balance    = balance_ff;
   assign cfg.input_rate = rate_ff;
   assign cfg.mono_input = mono_ff;

endmodule

>>> hdl/sgpr_ctrl.sv
`timescale 1ns / 1ps
module sgpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sgpr_pkg::status_type status,
   output sgpr_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_GAIN  = 9'b000000010,
      ST_CORR  = 9'b000000100,
      ST_SCALE = 9'b000001000,
      ST_ROUND = 9'b000010000,
      ST_PEAK  = 9'b000100000,
      ST_FRAC  = 9'b001000000,
      ST_MUL   = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.calc_gain = 1'b1;
            state_in      = ST_CORR;
         end
         ST_CORR: begin
            cmd.corr_gain = 1'b1;
            state_in      = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_out = 1'b1;
            state_in      = ST_PEAK;
         end
         ST_PEAK: begin
            cmd.peak = 1'b1;
            state_in = status.pass_mode ? ST_EMIT : ST_FRAC;
         end
         ST_FRAC: begin
            cmd.frac = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.pass_mode || status.phase_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FRAC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

>>> hdl/sgpr_datapath.sv
`timescale 1ns / 1ps
module sgpr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  sgpr_pkg::cmd_type    cmd,
   input  sgpr_pkg::cfg_type    cfg,
   input  logic                 rate_clear,
   input  logic signed [15:0]   req_left_sample,
   input  logic signed [15:0]   req_right_sample,
   input  logic                 req_block_end,
   output sgpr_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [15:0]   rsp_out_left,
   output logic signed [15:0]   rsp_out_right,
   output logic                 rsp_run_last,
   output logic                 rsp_peak_valid,
   output logic [15:0]          rsp_block_peak_out
);

   function automatic logic signed [16:0] round_q15(input logic signed [33:0] v);
      logic [33:0] mag_v;
      logic [33:0] sum_v;
      logic signed [16:0] r;
      mag_v = v[33] ? 34'(-v) : 34'(v);
      sum_v = mag_v + 34'(sgpr_pkg::Q15_HALF);
      r = $signed({1'b0, sum_v[30:15]});
      return v[33] ? -r : r;
   endfunction

   // Item pipeline registers.
   logic signed [15:0] smp_l_ff, smp_l_in, smp_r_ff, smp_r_in;
   logic               end_ff, end_in;
   logic [21:0]        num_l_ff, num_l_in, num_r_ff, num_r_in;
   logic [15:0]        qest_l_ff, qest_l_in, qest_r_ff, qest_r_in;
   logic [15:0]        gain_l_ff, gain_l_in, gain_r_ff, gain_r_in;
   logic signed [31:0] prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   logic signed [15:0] scl_l_ff, scl_l_in, scl_r_ff, scl_r_in;
   logic [15:0]        mag_l_ff, mag_l_in, mag_r_ff, mag_r_in;
   logic [15:0]        snap_ff, snap_in;
   logic [16:0]        phase_ff, phase_in;
   logic [15:0]        frac_ff, frac_in;
   logic signed [33:0] t_l_ff, t_l_in, t_r_ff, t_r_in;

   // Persistent state.
   logic               have_prev_ff, have_prev_in;
   logic signed [15:0] last_l_ff, last_l_in, last_r_ff, last_r_in;
   logic [15:0]        next_phase_ff, next_phase_in;
   logic [15:0]        peak_ff, peak_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic               rsp_run_last_ff, rsp_run_last_in;
   logic               rsp_peak_valid_ff, rsp_peak_valid_in;
   logic [15:0]        rsp_peak_ff, rsp_peak_in;

   logic [7:0]         vol_sat;
   logic signed [5:0]  bal_sat;
   logic [4:0]         bal_l, bal_r;
   logic [11:0]        vb_l, vb_r;
   logic [44:0]        qprod_l, qprod_r;
   logic [21:0]        rem_l, rem_r;
   logic signed [32:0] full_l, full_r;
   logic signed [16:0] rnd_l, rnd_r;
   logic [15:0]        pk_a, pk_b;
   logic [32:0]        fprod;
   logic signed [16:0] diff_l, diff_r;
   logic signed [16:0] lerp_l, lerp_r;
   logic signed [16:0] sum_l, sum_r;
   logic [16:0]        phase_sum;
   logic               pass_mode, phase_last, out_free, run_last;

   always_comb begin
      vol_sat = (cfg.volume > sgpr_pkg::VOL_MAX) ? sgpr_pkg::VOL_MAX : cfg.volume;
      if (cfg.balance < sgpr_pkg::BAL_MIN) begin
         bal_sat = sgpr_pkg::BAL_MIN;
      end else if (cfg.balance > sgpr_pkg::BAL_MAX) begin
         bal_sat = sgpr_pkg::BAL_MAX;
      end else begin
         bal_sat = cfg.balance;
      end
      bal_l = (bal_sat < 0) ? 5'(6'(sgpr_pkg::BAL_ONE) + 6'(bal_sat)) : sgpr_pkg::BAL_ONE;
      bal_r = (bal_sat > 0) ? 5'(6'(sgpr_pkg::BAL_ONE) - 6'(bal_sat)) : sgpr_pkg::BAL_ONE;
      vb_l  = 12'(vol_sat) * 12'(bal_l);
      vb_r  = 12'(vol_sat) * 12'(bal_r);

      qprod_l = 45'(num_l_ff) * 45'(sgpr_pkg::GAIN_RECIP);
      qprod_r = 45'(num_r_ff) * 45'(sgpr_pkg::GAIN_RECIP);
      rem_l   = num_l_ff - 22'(qest_l_ff) * 22'(sgpr_pkg::GAIN_DIV);
      rem_r   = num_r_ff - 22'(qest_r_ff) * 22'(sgpr_pkg::GAIN_DIV);

      full_l = smp_l_ff * $signed({1'b0, gain_l_ff});
      full_r = smp_r_ff * $signed({1'b0, gain_r_ff});
      rnd_l  = round_q15(34'(prod_l_ff));
      rnd_r  = round_q15(34'(prod_r_ff));

      pk_a = (mag_l_ff > peak_ff) ? mag_l_ff : peak_ff;
      pk_b = (mag_r_ff > pk_a) ? mag_r_ff : pk_a;

      fprod  = 33'(phase_ff[15:0]) * 33'(sgpr_pkg::FRAC_MUL) + 33'(sgpr_pkg::FRAC_BIAS);
      diff_l = 17'(scl_l_ff) - 17'(last_l_ff);
      diff_r = 17'(scl_r_ff) - 17'(last_r_ff);
      lerp_l = round_q15(t_l_ff);
      lerp_r = round_q15(t_r_ff);
      sum_l  = 17'(last_l_ff) + lerp_l;
      sum_r  = 17'(last_r_ff) + lerp_r;

      phase_sum  = phase_ff + 17'(cfg.input_rate);
      phase_last = phase_sum > 17'(sgpr_pkg::OUT_RATE);
      pass_mode  = (cfg.input_rate == sgpr_pkg::OUT_RATE) || !have_prev_ff;
      out_free   = !rsp_valid_ff || !rsp_stall;
      run_last   = pass_mode || phase_last;
   end

   always_comb begin
      smp_l_in          = smp_l_ff;
      smp_r_in          = smp_r_ff;
      end_in            = end_ff;
      num_l_in          = num_l_ff;
      num_r_in          = num_r_ff;
      qest_l_in         = qest_l_ff;
      qest_r_in         = qest_r_ff;
      gain_l_in         = gain_l_ff;
      gain_r_in         = gain_r_ff;
      prod_l_in         = prod_l_ff;
      prod_r_in         = prod_r_ff;
      scl_l_in          = scl_l_ff;
      scl_r_in          = scl_r_ff;
      mag_l_in          = mag_l_ff;
      mag_r_in          = mag_r_ff;
      snap_in           = snap_ff;
      phase_in          = phase_ff;
      frac_in           = frac_ff;
      t_l_in            = t_l_ff;
      t_r_in            = t_r_ff;
      have_prev_in      = have_prev_ff;
      last_l_in         = last_l_ff;
      last_r_in         = last_r_ff;
      next_phase_in     = next_phase_ff;
      peak_in           = peak_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_left_in       = rsp_left_ff;
      rsp_right_in      = rsp_right_ff;
      rsp_run_last_in   = rsp_run_last_ff;
      rsp_peak_valid_in = rsp_peak_valid_ff;
      rsp_peak_in       = rsp_peak_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load_item) begin
         smp_l_in = req_left_sample;
         smp_r_in = cfg.mono_input ? req_left_sample : req_right_sample;
         end_in   = req_block_end;
         num_l_in = {vb_l, 10'd0} + 22'(sgpr_pkg::GAIN_BIAS);
         num_r_in = {vb_r, 10'd0} + 22'(sgpr_pkg::GAIN_BIAS);
      end
      if (cmd.calc_gain) begin
         qest_l_in = qprod_l[44:29];
         qest_r_in = qprod_r[44:29];
      end
      if (cmd.corr_gain) begin
         gain_l_in = qest_l_ff + 16'(rem_l >= 22'(sgpr_pkg::GAIN_DIV));
         gain_r_in = qest_r_ff + 16'(rem_r >= 22'(sgpr_pkg::GAIN_DIV));
      end
      if (cmd.scale) begin
         prod_l_in = full_l[31:0];
         prod_r_in = full_r[31:0];
      end
      if (cmd.round_out) begin
         scl_l_in = rnd_l[15:0];
         scl_r_in = rnd_r[15:0];
         mag_l_in = rnd_l[16] ? 16'(-rnd_l) : 16'(rnd_l);
         mag_r_in = rnd_r[16] ? 16'(-rnd_r) : 16'(rnd_r);
      end
      if (cmd.peak) begin
         phase_in = {1'b0, next_phase_ff};
         if (end_ff) begin
            snap_in = pk_b;
            peak_in = '0;
         end else begin
            peak_in = pk_b;
         end
      end
      if (cmd.frac) begin
         frac_in = fprod[31:16];
      end
      if (cmd.mul) begin
         t_l_in = diff_l * $signed({1'b0, frac_ff});
         t_r_in = diff_r * $signed({1'b0, frac_ff});
      end
      if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_left_in       = pass_mode ? scl_l_ff : sum_l[15:0];
         rsp_right_in      = pass_mode ? scl_r_ff : sum_r[15:0];
         rsp_run_last_in   = run_last;
         rsp_peak_valid_in = end_ff && run_last;
         rsp_peak_in       = (end_ff && run_last) ? snap_ff : '0;
         if (pass_mode) begin
            if (cfg.input_rate != sgpr_pkg::OUT_RATE) begin
               have_prev_in  = 1'b1;
               last_l_in     = scl_l_ff;
               last_r_in     = scl_r_ff;
               next_phase_in = cfg.input_rate;
            end
         end else if (phase_last) begin
            next_phase_in = 16'(phase_sum - 17'(sgpr_pkg::OUT_RATE));
            last_l_in     = scl_l_ff;
            last_r_in     = scl_r_ff;
         end else begin
            phase_in = phase_sum;
         end
      end

      if (rate_clear) begin
         have_prev_in  = 1'b0;
         last_l_in     = '0;
         last_r_in     = '0;
         next_phase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         last_l_ff     <= '0;
         last_r_ff     <= '0;
         next_phase_ff <= '0;
         peak_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         have_prev_ff  <= have_prev_in;
         last_l_ff     <= last_l_in;
         last_r_ff     <= last_r_in;
         next_phase_ff <= next_phase_in;
         peak_ff       <= peak_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_l_ff          <= smp_l_in;
      smp_r_ff          <= smp_r_in;
      end_ff            <= end_in;
      num_l_ff          <= num_l_in;
      num_r_ff          <= num_r_in;
      qest_l_ff         <= qest_l_in;
      qest_r_ff         <= qest_r_in;
      gain_l_ff         <= gain_l_in;
      gain_r_ff         <= gain_r_in;
      prod_l_ff         <= prod_l_in;
      prod_r_ff         <= prod_r_in;
      scl_l_ff          <= scl_l_in;
      scl_r_ff          <= scl_r_in;
      mag_l_ff          <= mag_l_in;
      mag_r_ff          <= mag_r_in;
      snap_ff           <= snap_in;
      phase_ff          <= phase_in;
      frac_ff           <= frac_in;
      t_l_ff            <= t_l_in;
      t_r_ff            <= t_r_in;
      rsp_left_ff       <= rsp_left_in;
      rsp_right_ff      <= rsp_right_in;
      rsp_run_last_ff   <= rsp_run_last_in;
      rsp_peak_valid_ff <= rsp_peak_valid_in;
      rsp_peak_ff       <= rsp_peak_in;
   end

   assign status.pass_mode  = pass_mode;
   assign status.phase_last = phase_last;
   assign status.out_free   = out_free;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_left       = rsp_left_ff;
   assign rsp_out_right      = rsp_right_ff;
   assign rsp_run_last       = rsp_run_last_ff;
   assign rsp_peak_valid     = rsp_peak_valid_ff;
   assign rsp_block_peak_out = rsp_peak_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over an item still waiting");

   a_peak_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_peak_valid_ff) |-> rsp_run_last_ff)
      else $error("peak reported on an item that is not the last of its run");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      cmd.corr_gain |-> (rem_l < 22'd254 && rem_r < 22'd254))
      else $error("gain reciprocal estimate off by more than one");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      cmd.frac |-> (phase_ff <= 17'(sgpr_pkg::OUT_RATE) && phase_ff != 17'd0))
      else $error("interpolation phase outside its range");

endmodule

>>> hdl/stereo_gain_peak_resampler_top.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// req       req_valid / req_stall  left_sample, right_sample, block_end
// rsp       rsp_valid / rsp_stall  out_left, out_right, run_last, peak_valid, block_peak_out
// csr       csr_valid / csr_ready  csr_index, csr_wdata
//
// A pass-through item walks the gain, correction, scale, round, peak and emit steps
// after its acceptance, and the next item is accepted after that. An interpolating item
// walks the same steps up to peak, then the fraction, multiply and emit steps for each result in turn.
// Reset is synchronous and active high; it restores the configuration, the resampler
// state, the running peak and the controller to their defaults.
// Stall on rsp holds the result register and the emit step until it is taken;
// the next item is accepted while the last result still waits.
module stereo_gain_peak_resampler_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [15:0]     req_left_sample,
   input  logic signed [15:0]     req_right_sample,
   input  logic                   req_block_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [15:0]     rsp_out_left,
   output logic signed [15:0]     rsp_out_right,
   output logic                   rsp_run_last,
   output logic                   rsp_peak_valid,
   output logic [15:0]            rsp_block_peak_out,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  sgpr_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata
);

   sgpr_pkg::cfg_type    cfg;
   sgpr_pkg::cmd_type    cmd;
   sgpr_pkg::status_type status;
   logic                 rate_clear;

   sgpr_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cfg        (cfg),
      .rate_clear (rate_clear)
   );

   sgpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sgpr_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg                (cfg),
      .rate_clear         (rate_clear),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_block_end      (req_block_end),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_left       (rsp_out_left),
      .rsp_out_right      (rsp_out_right),
      .rsp_run_last       (rsp_run_last),
      .rsp_peak_valid     (rsp_peak_valid),
      .rsp_block_peak_out (rsp_block_peak_out)
   );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int unsigned OUTPUT_RATE = sgpr_pkg::OUT_RATE;
   localparam int unsigned LOWEST_RATE = sgpr_pkg::MIN_RATE;
   localparam int unsigned FRAC_STEP = sgpr_pkg::FRAC_MUL;
   localparam int unsigned FRAC_ROUND = sgpr_pkg::FRAC_BIAS;
   localparam int unsigned VOL_LIMIT = sgpr_pkg::VOL_MAX;
   localparam int BAL_UNITS = sgpr_pkg::BAL_ONE;
   localparam int unsigned GAIN_ONE = sgpr_pkg::GAIN_MAX;
   localparam int unsigned GAIN_DENOM = VOL_LIMIT * BAL_UNITS;
   localparam longint Q15_LONG = 32768;
   localparam longint ROUND_HALF = 16384;
   localparam int MAX_RUN = 6;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS = 22;
   localparam sgpr_pkg::csr_index_type REG_UNUSED_LO = 3'd4;
   localparam sgpr_pkg::csr_index_type REG_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic run_last;
      logic peak_valid;
      logic [15:0] peak;
   } audio_frame_type;

   typedef struct packed {
      logic is_write;
      sgpr_pkg::csr_index_type idx;
      logic [15:0] wdata;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic block_end;
      logic golden;
      logic signed [15:0] g_left;
      logic signed [15:0] g_right;
      logic [15:0] g_peak;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_left_sample = '0;
   logic signed [15:0] req_right_sample = '0;
   logic req_block_end = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_out_left;
   logic signed [15:0] rsp_out_right;
   logic rsp_run_last;
   logic rsp_peak_valid;
   logic [15:0] rsp_block_peak_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   sgpr_pkg::csr_index_type csr_index = sgpr_pkg::REG_VOLUME;
   logic [15:0] csr_wdata = '0;

   int unsigned cfg_volume = VOL_LIMIT;
   int cfg_balance = 0;
   int unsigned cfg_rate = OUTPUT_RATE;
   bit cfg_mono = 1'b0;
   bit primed = 1'b0;
   int prev_left = 0;
   int prev_right = 0;
   int unsigned phase = 0;
   int peak_hold = 0;

   audio_frame_type expected_frames[$];
   audio_frame_type last_predicted;
   stim_row_type directed_steps[$];

   int send_idle_pct = 0;
   int sink_stall_pct = 0;
   logic holding = 1'b0;
   event hold_go;

   int mismatch_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int peaks_seen = 0;
   int writes_done = 0;

   stereo_gain_peak_resampler_top u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned channel_gain(int unsigned vol, int unsigned bal16);
      return (vol * bal16 * GAIN_ONE + GAIN_DENOM / 2) / GAIN_DENOM;
   endfunction

   function automatic int scale_sample(int s, int unsigned g);
      longint prod;
      prod = longint'(s) * longint'(g);
      if (prod >= 0) return int'((prod + ROUND_HALF) / Q15_LONG);
      return -int'((-prod + ROUND_HALF) / Q15_LONG);
   endfunction

   function automatic int lerp_sample(int prev, int cur, int unsigned frac);
      longint t;
      t = longint'(cur - prev) * longint'(frac);
      t += (t >= 0) ? ROUND_HALF : -ROUND_HALF;
      return prev + int'(t / Q15_LONG);
   endfunction

   function automatic audio_frame_type frame_of(int l, int r);
      audio_frame_type f;
      f = '0;
      f.left = l[15:0];
      f.right = r[15:0];
      return f;
   endfunction

   function automatic void apply_reg(sgpr_pkg::csr_index_type idx, logic [15:0] data);
      case (idx)
         sgpr_pkg::REG_VOLUME: cfg_volume = data[7:0];
         sgpr_pkg::REG_BALANCE: cfg_balance = $signed(data[5:0]);
         sgpr_pkg::REG_INPUT_RATE: begin
            if (data >= LOWEST_RATE && data <= OUTPUT_RATE && data != cfg_rate) begin
               cfg_rate = data;
               primed = 1'b0;
               prev_left = 0;
               prev_right = 0;
               phase = 0;
            end
         end
         sgpr_pkg::REG_MONO_INPUT: cfg_mono = data[0];
         default: ;
      endcase
   endfunction

   function automatic void frame_predict(logic signed [15:0] left_in,
                                         logic signed [15:0] right_in, logic block_end);
      int unsigned vol, left_gain, right_gain, p, frac;
      int bal, sl, sr, l, r;
      audio_frame_type res;
      audio_frame_type run[$];
      vol = (cfg_volume > VOL_LIMIT) ? VOL_LIMIT : cfg_volume;
      bal = (cfg_balance < -BAL_UNITS) ? -BAL_UNITS
            : ((cfg_balance > BAL_UNITS) ? BAL_UNITS : cfg_balance);
      left_gain = channel_gain(vol, (bal < 0) ? BAL_UNITS + bal : BAL_UNITS);
      right_gain = channel_gain(vol, (bal > 0) ? BAL_UNITS - bal : BAL_UNITS);
      sl = left_in;
      sr = cfg_mono ? left_in : right_in;
      l = scale_sample(sl, left_gain);
      r = scale_sample(sr, right_gain);
      if (((l < 0) ? -l : l) > peak_hold) peak_hold = (l < 0) ? -l : l;
      if (((r < 0) ? -r : r) > peak_hold) peak_hold = (r < 0) ? -r : r;
      if (cfg_rate == OUTPUT_RATE) begin
         run.push_back(frame_of(l, r));
      end else if (!primed) begin
         primed = 1'b1;
         prev_left = l;
         prev_right = r;
         phase = cfg_rate;
         run.push_back(frame_of(l, r));
      end else begin
         p = phase;
         while (p <= OUTPUT_RATE && run.size() < MAX_RUN) begin
            frac = (p * FRAC_STEP + FRAC_ROUND) >> 16;
            run.push_back(frame_of(lerp_sample(prev_left, l, frac),
                                   lerp_sample(prev_right, r, frac)));
            p += cfg_rate;
         end
         while (p <= OUTPUT_RATE) p += cfg_rate;
         phase = (p - OUTPUT_RATE) & 32'hFFFF;
         prev_left = l;
         prev_right = r;
      end
      res = run.pop_back();
      res.run_last = 1'b1;
      if (block_end) begin
         res.peak_valid = 1'b1;
         res.peak = peak_hold[15:0];
         peak_hold = 0;
      end
      run.push_back(res);
      foreach (run[i]) expected_frames.push_back(run[i]);
      last_predicted = res;
   endfunction

   function automatic void flag_mismatch(string what, audio_frame_type want,
                                         audio_frame_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected L=%0d R=%0d last=%0b pv=%0b peak=%0d,",
                  $time, what, want.left, want.right, want.run_last, want.peak_valid,
                  want.peak, " got L=%0d R=%0d last=%0b pv=%0b peak=%0d",
                  got.left, got.right, got.run_last, got.peak_valid, got.peak);
   endfunction

   function automatic void add_write(sgpr_pkg::csr_index_type idx, int data);
      stim_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.idx = idx;
      row.wdata = 16'(data);
      directed_steps.push_back(row);
   endfunction

   function automatic void add_frame(int l, int r, bit be, bit golden = 1'b0,
                                     int gl = 0, int gr = 0, int gp = 0);
      stim_row_type row;
      row = '0;
      row.left = 16'(l);
      row.right = 16'(r);
      row.block_end = be;
      row.golden = golden;
      row.g_left = 16'(gl);
      row.g_right = 16'(gr);
      row.g_peak = 16'(gp);
      directed_steps.push_back(row);
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(3, 0))
         0: return $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
         1: return 16'($urandom_range(512, 0) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r, logic be);
      csr_valid <= 1'b0;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_left_sample <= l;
      req_right_sample <= r;
      req_block_end <= be;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frame_predict(l, r, be);
      items_sent++;
   endtask

   task automatic write_reg(sgpr_pkg::csr_index_type idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, data);
      writes_done++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int send_pct, int sink_pct, bit pressure);
      logic [15:0] rate;
      wait_idle();
      case ($urandom_range(5, 0))
         0: rate = sgpr_pkg::MIN_RATE;
         1: rate = sgpr_pkg::OUT_RATE;
         2: rate = 16'd44100;
         3: rate = 16'd22050;
         4: rate = 16'($urandom_range(OUTPUT_RATE, LOWEST_RATE));
         default: rate = 16'($urandom);
      endcase
      write_reg(sgpr_pkg::REG_VOLUME, 16'($urandom));
      write_reg(sgpr_pkg::REG_BALANCE, 16'($urandom));
      write_reg(sgpr_pkg::REG_INPUT_RATE, rate);
      write_reg(sgpr_pkg::REG_MONO_INPUT, 16'($urandom));
      write_reg(REG_UNUSED_LO + 3'($urandom_range(3, 0)), 16'($urandom));
      send_idle_pct = send_pct;
      sink_stall_pct = sink_pct;
      if (pressure) -> hold_go;
      repeat (PHASE_ITEMS)
         send_frame(pick_sample(), pick_sample(), $urandom_range(3, 0) == 0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= holding || ($urandom_range(99, 0) < sink_stall_pct);
      end
   end

   initial forever begin
      @(hold_go);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   always @(posedge clock) begin : result_check
      audio_frame_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_left, rsp_out_right, rsp_run_last, rsp_peak_valid, rsp_block_peak_out};
         if (expected_frames.size() == 0) begin
            flag_mismatch("unexpected item", '0, got);
         end else begin
            want = expected_frames.pop_front();
            results_checked++;
            if (got.peak_valid) peaks_seen++;
            if (got !== want) flag_mismatch("item mismatch", want, got);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      stim_row_type row;
      audio_frame_type want;
      bit frames_since_write;
      frames_since_write = 1'b0;

      add_frame(32767, -32768, 1, 1, 32767, -32768, 32768);
      add_frame(-32768, 32767, 0, 1, -32768, 32767, 0);
      add_frame(5, -3, 1, 1, 5, -3, 32768);
      add_frame(0, 0, 1, 1, 0, 0, 0);
      add_write(sgpr_pkg::REG_VOLUME, 0);
      add_frame(32767, -32768, 1, 1, 0, 0, 0);
      add_write(sgpr_pkg::REG_VOLUME, 16'hFFFF);
      add_write(REG_UNUSED_LO, 0);
      add_write(REG_UNUSED_HI, 16'h1234);
      add_frame(-12345, 23456, 1, 1, -12345, 23456, 23456);
      add_write(sgpr_pkg::REG_BALANCE, 16'h0030);
      add_frame(1000, -2000, 1, 1, 0, -2000, 2000);
      add_write(sgpr_pkg::REG_BALANCE, 16'h001F);
      add_frame(1000, -2000, 1, 1, 1000, 0, 1000);
      add_write(sgpr_pkg::REG_BALANCE, 16'h0010);
      add_frame(-1, 1, 0, 1, -1, 0, 0);
      add_write(sgpr_pkg::REG_BALANCE, 0);
      add_write(sgpr_pkg::REG_MONO_INPUT, 1);
      add_frame(-777, 4321, 1, 1, -777, -777, 777);
      add_write(sgpr_pkg::REG_MONO_INPUT, 0);
      add_write(sgpr_pkg::REG_INPUT_RATE, 7999);
      add_write(sgpr_pkg::REG_INPUT_RATE, 48001);
      add_write(sgpr_pkg::REG_INPUT_RATE, 16'hFFFF);
      add_frame(11, 22, 1, 1, 11, 22, 22);
      add_write(sgpr_pkg::REG_INPUT_RATE, 8000);
      add_frame(16000, -16000, 0, 1, 16000, -16000, 0);
      add_frame(-32768, 32767, 1);
      add_write(sgpr_pkg::REG_INPUT_RATE, 8000);
      add_frame(32767, -32768, 0);
      add_frame(0, 0, 1);
      add_write(sgpr_pkg::REG_INPUT_RATE, 44100);
      add_write(sgpr_pkg::REG_VOLUME, 127);
      add_write(sgpr_pkg::REG_BALANCE, 16'h003B);
      add_frame(20000, -20000, 0);
      add_frame(-20000, 20000, 0);
      add_frame(123, -456, 1);
      add_write(sgpr_pkg::REG_INPUT_RATE, 11025);
      add_write(sgpr_pkg::REG_MONO_INPUT, 1);
      add_frame(30000, 1, 0);
      add_frame(-30000, 1, 1);
      add_write(sgpr_pkg::REG_INPUT_RATE, 48000);
      add_write(sgpr_pkg::REG_VOLUME, 254);
      add_write(sgpr_pkg::REG_BALANCE, 0);
      add_write(sgpr_pkg::REG_MONO_INPUT, 0);
      add_frame(32767, 32767, 1, 1, 32767, 32767, 32767);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         row = directed_steps[i];
         if (row.is_write) begin
            if (frames_since_write) wait_idle();
            frames_since_write = 1'b0;
            write_reg(row.idx, row.wdata);
         end else begin
            send_frame(row.left, row.right, row.block_end);
            frames_since_write = 1'b1;
            if (row.golden) begin
               want = '0;
               want.left = row.g_left;
               want.right = row.g_right;
               want.run_last = 1'b1;
               want.peak_valid = row.block_end;
               want.peak = row.block_end ? row.g_peak : '0;
               if (last_predicted !== want)
                  flag_mismatch("directed table", want, last_predicted);
            end
         end
      end

      run_phase(0, 0, 1'b0);
      run_phase(63, 0, 1'b0);
      run_phase(0, 63, 1'b0);
      run_phase(31, 31, 1'b0);
      run_phase(0, 0, 1'b1);
      wait_idle();

      $display("Sent %0d frames and checked %0d output frames, %0d of them closing a block.",
               items_sent, results_checked, peaks_seen);
      $display("Made %0d register writes over pass-through and interpolating rates,",
               writes_done, " with idle sender, stalled receiver and a long hold.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/sgpr_pkg.sv
hdl/sgpr_csr.sv
hdl/sgpr_ctrl.sv
hdl/sgpr_datapath.sv
hdl/stereo_gain_peak_resampler_top.sv
test/testbench.sv
